// ----- src/sbda_pkg.sv -----
// ----------------------------------------------------------------------------
// sbda_pkg
// Shared types and constants for the signed binary to decimal ASCII converter.
// ----------------------------------------------------------------------------
package sbda_pkg;

	localparam int VALUE_WIDTH = 32;
	localparam int DIGITS      = (VALUE_WIDTH * 30103) / 100000 + 1;
	localparam int BCD_W       = DIGITS * 4;
	localparam int BIT_CNT_W   = $clog2(VALUE_WIDTH + 1);
	localparam int DIG_CNT_W   = $clog2(DIGITS + 1);

	localparam logic [7:0] CHAR_ZERO  = 8'd48;
	localparam logic [7:0] CHAR_MINUS = 8'd45;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONVERT,
		ST_SKIP,
		ST_SIGN,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic dabble;
		logic skip;
		logic emit_sign;
		logic emit_digit;
	} cmd_t;

	typedef struct packed {
		logic bits_last;
		logic top_zero;
		logic one_left;
		logic negative;
		logic out_free;
	} status_t;

endpackage

// ----- src/sbda_datapath.sv -----
// ----------------------------------------------------------------------------
// sbda_datapath
// Magnitude and BCD registers with shift-add-3 conversion, leading-zero
// shifting and the output character register.
// ----------------------------------------------------------------------------
module sbda_datapath (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic signed [sbda_pkg::VALUE_WIDTH-1:0] value,
	input  sbda_pkg::cmd_t                       cmd,
	output sbda_pkg::status_t                    status,
	output logic [7:0]                           character,
	output logic                                 last,
	output logic                                 char_valid,
	input  logic                                 char_stall
);

	logic [sbda_pkg::VALUE_WIDTH-1:0] mag_q;
	logic [sbda_pkg::BCD_W-1:0]       bcd_q;
	logic                             neg_q;
	logic [sbda_pkg::BIT_CNT_W-1:0]   bit_cnt_q;
	logic [sbda_pkg::DIG_CNT_W-1:0]   dig_cnt_q;
	logic [7:0]                       char_q;
	logic                             last_q;
	logic                             valid_q;

	logic [sbda_pkg::BCD_W-1:0]       bcd_dabble;
	logic [sbda_pkg::VALUE_WIDTH-1:0] abs_value;
	logic [3:0]                       top_digit;

	assign abs_value = value[sbda_pkg::VALUE_WIDTH-1] ? (~value + 1'b1) : value;
	assign top_digit = bcd_q[sbda_pkg::BCD_W-1 -: 4];

	always_comb begin
		logic [sbda_pkg::BCD_W-1:0] adj;
		logic [3:0]                 d;
		adj = '0;
		for (int i = 0; i < sbda_pkg::DIGITS; i++) begin
			d = bcd_q[i*4 +: 4];
			adj[i*4 +: 4] = (d >= 4'd5) ? d + 4'd3 : d;
		end
		bcd_dabble = {adj[sbda_pkg::BCD_W-2:0], mag_q[sbda_pkg::VALUE_WIDTH-1]};
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mag_q     <= abs_value;
			bcd_q     <= '0;
			neg_q     <= value[sbda_pkg::VALUE_WIDTH-1];
			bit_cnt_q <= sbda_pkg::BIT_CNT_W'(sbda_pkg::VALUE_WIDTH);
			dig_cnt_q <= sbda_pkg::DIG_CNT_W'(sbda_pkg::DIGITS);
		end else if (cmd.dabble) begin
			mag_q     <= {mag_q[sbda_pkg::VALUE_WIDTH-2:0], 1'b0};
			bcd_q     <= bcd_dabble;
			bit_cnt_q <= bit_cnt_q - 1'b1;
		end else if (cmd.skip || cmd.emit_digit) begin
			bcd_q     <= {bcd_q[sbda_pkg::BCD_W-5:0], 4'd0};
			dig_cnt_q <= dig_cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_sign) begin
			char_q <= sbda_pkg::CHAR_MINUS;
			last_q <= 1'b0;
		end else if (cmd.emit_digit) begin
			char_q <= sbda_pkg::CHAR_ZERO + {4'd0, top_digit};
			last_q <= (dig_cnt_q == sbda_pkg::DIG_CNT_W'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.emit_sign || cmd.emit_digit) begin
			valid_q <= 1'b1;
		end else if (!char_stall) begin
			valid_q <= 1'b0;
		end
	end

	assign status.bits_last = (bit_cnt_q == sbda_pkg::BIT_CNT_W'(1));
	assign status.top_zero  = (top_digit == 4'd0);
	assign status.one_left  = (dig_cnt_q == sbda_pkg::DIG_CNT_W'(1));
	assign status.negative  = neg_q;
	assign status.out_free  = !valid_q || !char_stall;

	assign character  = char_q;
	assign last       = last_q;
	assign char_valid = valid_q;

endmodule

// ----- src/sbda_ctrl.sv -----
// ----------------------------------------------------------------------------
// sbda_ctrl
// Sequencer for load, conversion, leading-zero suppression and character
// output.
// ----------------------------------------------------------------------------
module sbda_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              value_valid,
	output logic              value_stall,
	input  sbda_pkg::status_t status,
	output sbda_pkg::cmd_t    cmd
);

	sbda_pkg::state_t state_q;
	sbda_pkg::state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sbda_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next  = state_q;
		cmd         = '0;
		value_stall = 1'b1;
		unique case (state_q)
			sbda_pkg::ST_IDLE: begin
				value_stall = 1'b0;
				if (value_valid) begin
					cmd.load   = 1'b1;
					state_next = sbda_pkg::ST_CONVERT;
				end
			end
			sbda_pkg::ST_CONVERT: begin
				cmd.dabble = 1'b1;
				if (status.bits_last) begin
					state_next = sbda_pkg::ST_SKIP;
				end
			end
			sbda_pkg::ST_SKIP: begin
				if (status.top_zero && !status.one_left) begin
					cmd.skip = 1'b1;
				end else if (status.negative) begin
					state_next = sbda_pkg::ST_SIGN;
				end else begin
					state_next = sbda_pkg::ST_EMIT;
				end
			end
			sbda_pkg::ST_SIGN: begin
				if (status.out_free) begin
					cmd.emit_sign = 1'b1;
					state_next    = sbda_pkg::ST_EMIT;
				end
			end
			sbda_pkg::ST_EMIT: begin
				if (status.out_free) begin
					cmd.emit_digit = 1'b1;
					if (status.one_left) begin
						state_next = sbda_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_next = sbda_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ----- src/signed_binary_to_decimal_ascii.sv -----
// ----------------------------------------------------------------------------
// signed_binary_to_decimal_ascii
// Converts a signed two's complement integer into its decimal ASCII text.
// ----------------------------------------------------------------------------
// Each accepted value is printed as a leading '-' when negative, then its
// decimal digits most significant first with leading zeros suppressed; zero
// prints as a single '0', and the most negative value prints in full. The
// last character of every number has last set. One value is handled at a
// time: the conversion runs shift-add-3 over one input bit per cycle. Each
// item passes through the input transfer, the conversion, the skipping of
// leading zeros and then its characters, one at a time through the output
// register, where the output stall can hold them.
// ----------------------------------------------------------------------------
module signed_binary_to_decimal_ascii (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic signed [sbda_pkg::VALUE_WIDTH-1:0] value,
	input  logic                                    value_valid,
	output logic                                    value_stall,
	output logic [7:0]                              character,
	output logic                                    last,
	output logic                                    char_valid,
	input  logic                                    char_stall
);

	sbda_pkg::cmd_t    cmd;
	sbda_pkg::status_t status;

	sbda_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.value_valid (value_valid),
		.value_stall (value_stall),
		.status      (status),
		.cmd         (cmd)
	);

	sbda_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.value      (value),
		.cmd        (cmd),
		.status     (status),
		.character  (character),
		.last       (last),
		.char_valid (char_valid),
		.char_stall (char_stall)
	);

endmodule

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the signed binary to decimal ASCII converter.
// ----------------------------------------------------------------------------
// A directed table covers zero, single digits, the largest and most negative
// values and the digit-count boundaries. Random values follow in four phases
// of sender idling and receiver stalling. Each value without an expected
// text is spelled out in decimal by a local predictor. Each character
// transfer is compared against the oldest owed character.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int QUIET_LIMIT  = 5000;
	localparam int TAIL_CYCLES  = 60;
	localparam int RANDOM_ITEMS = 380;

	typedef struct {
		logic [7:0] code;
		logic       is_last;
	} ascii_char_t;

	typedef struct {
		logic [sbda_pkg::VALUE_WIDTH-1:0] number;
		string                            text;
	} number_row_t;

	logic                             clk         = 1'b0;
	logic                             arst_n      = 1'b0;
	logic [sbda_pkg::VALUE_WIDTH-1:0] value       = '0;
	logic                             value_valid = 1'b0;
	logic                             value_stall;
	logic [7:0]                       character;
	logic                             last;
	logic                             char_valid;
	logic                             char_stall  = 1'b0;

	ascii_char_t owed_chars[$];
	ascii_char_t head_char;
	int idle_pct       = 0;
	int stall_pct      = 0;
	int error_count    = 0;
	int values_sent    = 0;
	int negatives_sent = 0;
	int chars_checked  = 0;
	int quiet_cycles   = 0;

	// An empty text means the row is checked against the predictor.
	number_row_t directed_rows[19] = '{
		'{32'd0,          "0"},
		'{32'd1,          "1"},
		'{32'hFFFF_FFFF,  "-1"},
		'{32'd9,          "9"},
		'{32'd10,         "10"},
		'{32'hFFFF_FFF6,  "-10"},
		'{32'h7FFF_FFFF,  "2147483647"},
		'{32'h8000_0000,  "-2147483648"},
		'{32'h8000_0001,  ""},
		'{32'hFFFF_FFFE,  ""},
		'{32'd1000000000, ""},
		'{32'd999999999,  ""},
		'{32'(-1000000000), ""},
		'{32'(-999999999),  ""},
		'{32'h5555_5555,  ""},
		'{32'hAAAA_AAAA,  ""},
		'{32'd100,        ""},
		'{32'd12345,      ""},
		'{32'(-9),        ""}
	};

	signed_binary_to_decimal_ascii DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.value       (value),
		.value_valid (value_valid),
		.value_stall (value_stall),
		.character   (character),
		.last        (last),
		.char_valid  (char_valid),
		.char_stall  (char_stall)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic void spell_decimal(input logic [sbda_pkg::VALUE_WIDTH-1:0] number);
		logic [sbda_pkg::VALUE_WIDTH-1:0] magnitude;
		logic [3:0]                       digits[$];
		int                               i;
		magnitude = number[sbda_pkg::VALUE_WIDTH-1] ? (~number + 1'b1) : number;
		if (number[sbda_pkg::VALUE_WIDTH-1]) begin
			owed_chars.push_back('{sbda_pkg::CHAR_MINUS, 1'b0});
		end
		do begin
			digits.push_front(4'(magnitude % 10));
			magnitude = magnitude / 10;
		end while (magnitude != 0);
		for (i = 0; i < digits.size(); i++) begin
			owed_chars.push_back('{sbda_pkg::CHAR_ZERO + digits[i],
				i == digits.size() - 1});
		end
	endfunction

	function automatic logic [sbda_pkg::VALUE_WIDTH-1:0] random_number();
		logic [sbda_pkg::VALUE_WIDTH-1:0] number;
		logic [sbda_pkg::VALUE_WIDTH-1:0] power;
		int                               k;
		case ($urandom_range(4))
			0: begin
				number = $urandom;
			end
			1: begin
				number = $urandom_range(2000);
				number = number - 1000;
			end
			2: begin
				power = 1;
				for (k = $urandom_range(9); k > 0; k--) begin
					power = power * 10;
				end
				number = power + $urandom_range(2) - 1;
			end
			3: begin
				if ($urandom_range(1)) begin
					number = {1'b0, {(sbda_pkg::VALUE_WIDTH-1){1'b1}}} - $urandom_range(3);
				end else begin
					number = {1'b1, {(sbda_pkg::VALUE_WIDTH-1){1'b0}}} + $urandom_range(3);
				end
			end
			default: begin
				number = $urandom >> $urandom_range(31);
			end
		endcase
		if ($urandom_range(1)) begin
			number = -number;
		end
		return number;
	endfunction

	task automatic send_value(input logic [sbda_pkg::VALUE_WIDTH-1:0] number,
		input string text);
		int i;
		while ($urandom_range(99) < idle_pct) begin
			value_valid <= 1'b0;
			value       <= $urandom;
			@(posedge clk);
		end
		value       <= number;
		value_valid <= 1'b1;
		do @(posedge clk); while (value_stall !== 1'b0);
		if (text.len() == 0) begin
			spell_decimal(number);
		end else begin
			for (i = 0; i < text.len(); i++) begin
				owed_chars.push_back('{text[i], i == text.len() - 1});
			end
		end
		values_sent++;
		if (number[sbda_pkg::VALUE_WIDTH-1]) begin
			negatives_sent++;
		end
	endtask

	task automatic drain_results();
		value_valid <= 1'b0;
		do @(posedge clk); while (owed_chars.size() != 0);
	endtask

	always @(posedge clk) begin
		char_stall <= ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		if (char_valid && !char_stall) begin
			if (owed_chars.size() == 0) begin
				$display("%0t: character %0d (last %b) with nothing owed",
					$time, character, last);
				error_count++;
			end else begin
				head_char = owed_chars.pop_front();
				if (character !== head_char.code) begin
					$display("%0t: character expected %0d actual %0d",
						$time, head_char.code, character);
					error_count++;
				end
				if (last !== head_char.is_last) begin
					$display("%0t: last expected %b actual %b",
						$time, head_char.is_last, last);
					error_count++;
				end
				chars_checked++;
			end
		end
	end

	always @(posedge clk) begin
		if ((value_valid && !value_stall) || (char_valid && !char_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no transfer for %0d cycles, %0d characters still owed",
				$time, quiet_cycles, owed_chars.size());
			$display("status: fail");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int i;
		int phase;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (i = 0; i < $size(directed_rows); i++) begin
			send_value(directed_rows[i].number, directed_rows[i].text);
		end
		drain_results();
		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					idle_pct  = 0;
					stall_pct = 0;
				end
				1: begin
					idle_pct  = 50;
					stall_pct = 0;
				end
				2: begin
					idle_pct  = 0;
					stall_pct = 50;
				end
				default: begin
					idle_pct  = 33;
					stall_pct = 33;
				end
			endcase
			for (i = 0; i < RANDOM_ITEMS / 4; i++) begin
				send_value(random_number(), "");
			end
			drain_results();
		end
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Converted %0d values (%0d negative) into %0d checked characters,",
			values_sent, negatives_sent, chars_checked);
		$display("from the extremes and digit boundaries through four idle and stall mixes.");
		if (error_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
